FILE: rtl/usbcep_pkg.sv
// Shared types, codes and descriptor ROM for the USB control endpoint engine.
package usbcep_pkg;

  localparam int RomBytes = 123;

  typedef enum logic [2:0] {
    ACT_SETUP   = 3'd0,
    ACT_IN_DONE = 3'd1,
    ACT_OUT_DONE = 3'd2,
    ACT_BUS_RESET = 3'd3,
    ACT_SUSPEND = 3'd4
  } action_t;

  localparam logic [1:0] HS_NAK   = 2'd0;
  localparam logic [1:0] HS_ACK   = 2'd1;
  localparam logic [1:0] HS_STALL = 2'd2;
  localparam logic [1:0] HS_KEEP  = 2'd3;

  localparam logic [1:0] BULK_NONE = 2'd0;
  localparam logic [1:0] BULK_IN   = 2'd1;
  localparam logic [1:0] BULK_OUT  = 2'd2;

  localparam logic [7:0] REQ_GET_STATUS    = 8'd0;
  localparam logic [7:0] REQ_CLEAR_FEATURE = 8'd1;
  localparam logic [7:0] REQ_SET_ADDRESS   = 8'd5;
  localparam logic [7:0] REQ_GET_DESC      = 8'd6;
  localparam logic [7:0] REQ_GET_CONFIG    = 8'd8;
  localparam logic [7:0] REQ_SET_CONFIG    = 8'd9;
  localparam logic [7:0] REQ_GET_IFACE     = 8'd10;
  localparam logic [7:0] REQ_SET_IFACE     = 8'd11;
  localparam logic [7:0] REQ_SET_LINE      = 8'h20;
  localparam logic [7:0] REQ_GET_LINE      = 8'h21;

  localparam logic [0:0] CFG_VENDOR  = 1'b0;
  localparam logic [0:0] CFG_PRODUCT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT
  } state_t;

  function automatic logic [7:0] rom_byte(input logic [6:0] a);
    logic [7:0] r;
    begin
      unique case (a)
        7'd0: r = 8'h12; 7'd1: r = 8'h01; 7'd2: r = 8'h10; 7'd3: r = 8'h01;
        7'd4: r = 8'h02; 7'd5: r = 8'h00; 7'd6: r = 8'h00; 7'd7: r = 8'h40;
        7'd8: r = 8'h86; 7'd9: r = 8'h1A; 7'd10: r = 8'h0C; 7'd11: r = 8'hFE;
        7'd12: r = 8'h00; 7'd13: r = 8'h01; 7'd14: r = 8'h01; 7'd15: r = 8'h02;
        7'd16: r = 8'h00; 7'd17: r = 8'h01;
        7'd18: r = 8'h09; 7'd19: r = 8'h02; 7'd20: r = 8'h43; 7'd21: r = 8'h00;
        7'd22: r = 8'h02; 7'd23: r = 8'h01; 7'd24: r = 8'h00; 7'd25: r = 8'h80;
        7'd26: r = 8'h32;
        7'd27: r = 8'h09; 7'd28: r = 8'h04; 7'd29: r = 8'h00; 7'd30: r = 8'h00;
        7'd31: r = 8'h01; 7'd32: r = 8'h02; 7'd33: r = 8'h02; 7'd34: r = 8'h01;
        7'd35: r = 8'h00;
        7'd36: r = 8'h05; 7'd37: r = 8'h24; 7'd38: r = 8'h00; 7'd39: r = 8'h10;
        7'd40: r = 8'h01;
        7'd41: r = 8'h05; 7'd42: r = 8'h24; 7'd43: r = 8'h01; 7'd44: r = 8'h00;
        7'd45: r = 8'h01;
        7'd46: r = 8'h04; 7'd47: r = 8'h24; 7'd48: r = 8'h02; 7'd49: r = 8'h02;
        7'd50: r = 8'h05; 7'd51: r = 8'h24; 7'd52: r = 8'h06; 7'd53: r = 8'h00;
        7'd54: r = 8'h01;
        7'd55: r = 8'h07; 7'd56: r = 8'h05; 7'd57: r = 8'h81; 7'd58: r = 8'h03;
        7'd59: r = 8'h40; 7'd60: r = 8'h00; 7'd61: r = 8'h01;
        7'd62: r = 8'h09; 7'd63: r = 8'h04; 7'd64: r = 8'h01; 7'd65: r = 8'h00;
        7'd66: r = 8'h02; 7'd67: r = 8'h0A; 7'd68: r = 8'h00; 7'd69: r = 8'h00;
        7'd70: r = 8'h00;
        7'd71: r = 8'h07; 7'd72: r = 8'h05; 7'd73: r = 8'h02; 7'd74: r = 8'h02;
        7'd75: r = 8'h40; 7'd76: r = 8'h00; 7'd77: r = 8'h00;
        7'd78: r = 8'h07; 7'd79: r = 8'h05; 7'd80: r = 8'h83; 7'd81: r = 8'h02;
        7'd82: r = 8'h40; 7'd83: r = 8'h00; 7'd84: r = 8'h00;
        7'd85: r = 8'h04; 7'd86: r = 8'h03; 7'd87: r = 8'h09; 7'd88: r = 8'h04;
        7'd89: r = 8'h0E; 7'd90: r = 8'h03; 7'd91: r = 8'h77; 7'd92: r = 8'h00;
        7'd93: r = 8'h63; 7'd94: r = 8'h00; 7'd95: r = 8'h68; 7'd96: r = 8'h00;
        7'd97: r = 8'h2E; 7'd98: r = 8'h00; 7'd99: r = 8'h63; 7'd100: r = 8'h00;
        7'd101: r = 8'h6E; 7'd102: r = 8'h00;
        7'd103: r = 8'h14; 7'd104: r = 8'h03; 7'd105: r = 8'h48; 7'd106: r = 8'h00;
        7'd107: r = 8'h75; 7'd108: r = 8'h00; 7'd109: r = 8'h72; 7'd110: r = 8'h00;
        7'd111: r = 8'h72; 7'd112: r = 8'h00; 7'd113: r = 8'h61; 7'd114: r = 8'h00;
        7'd115: r = 8'h20; 7'd116: r = 8'h00; 7'd117: r = 8'h43; 7'd118: r = 8'h00;
        7'd119: r = 8'h44; 7'd120: r = 8'h00; 7'd121: r = 8'h43; 7'd122: r = 8'h00;
        default: r = 8'h00;
      endcase
      return r;
    end
  endfunction

endpackage

FILE: rtl/usb_control_endpoint_engine.sv
// Endpoint-0 control engine: standard and CDC requests, descriptor walk.
//
// Input channel: one event per beat (setup, IN done, OUT done, bus reset,
// suspend change) with valid/stall. Output channel: result beats with
// valid/stall; an event with a payload gives one beat per byte, else one
// beat with byte_valid low; last marks the final beat of the event.
// Configuration: cfg_valid/cfg_ready write vendor_id (index 0) or
// product_id (index 1); patched into device descriptor bytes 8 to 11.
// Timing: the event is decoded in the cycle it is accepted and its results are
// registered; its beats then leave one a cycle while the output is not stalled.
// The byte path reads one descriptor ROM byte or line-coding byte per cycle while
// beats are taken, through a shared byte counter.
// The input is stalled while beats of the event are pending.
// Reset (rst, synchronous) returns the state machine to idle, line coding to
// 115200 8N1, address and configuration to zero. A stalled output beat
// holds; the byte counter advances only when a beat is taken.
module usb_control_endpoint_engine
  import usbcep_pkg::*;
#(
  parameter int EP0_PACKET_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  action,
  input  logic [7:0]  request_type,
  input  logic [7:0]  request_code,
  input  logic [15:0] request_value,
  input  logic [15:0] request_index,
  input  logic [15:0] request_length,
  input  logic        toggle_ok,
  input  logic [6:0]  out_count,
  input  logic [55:0] out_bytes,
  input  logic        suspended,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  tx_handshake,
  output logic [1:0]  rx_handshake,
  output logic        tx_toggle,
  output logic        rx_toggle,
  output logic [6:0]  tx_length,
  output logic [7:0]  data_byte,
  output logic        byte_valid,
  output logic        last,
  output logic [6:0]  device_address,
  output logic        configured,
  output logic [1:0]  bulk_reset,
  output logic        sleeping,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam logic [6:0] PktBytes = 7'(EP0_PACKET_BYTES);
  localparam logic [7:0] RomEnd = 8'(RomBytes);

  state_t state, state_next;

  logic [15:0] vendor_id, product_id;
  logic [7:0]  saved_type, saved_code;
  logic [15:0] remaining_bytes;
  logic [6:0]  rom_pointer, pending_address, bus_address;
  logic [7:0]  config_value;
  logic        is_configured, sleep_flag, in_toggle, rx_tog;
  logic [55:0] line_coding;

  // byte walk: source select, start address and count
  logic        src_rom, src_line, src_cfg;
  logic [7:0]  walk_addr;
  logic [6:0]  walk_count, walk_idx;

  // decode results of the current event
  logic [1:0]  txh, rxh, bulk;
  logic [6:0]  txlen;

  // next values computed at accept
  logic [1:0]  n_txh, n_rxh, n_bulk;
  logic [6:0]  n_len, n_rom_pointer, n_pending, n_bus;
  logic [15:0] n_rem;
  logic [7:0]  n_type, n_code, n_cfgval, n_base, n_walk;
  logic        n_conf, n_sleep, n_intog, n_rxtog, n_src_rom, n_src_line, n_src_cfg;
  logic [55:0] n_line;

  logic [7:0]  cur_byte;
  logic        accept, beat;

  assign accept    = in_valid && !in_stall;
  assign beat      = out_valid && !out_stall;
  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  function automatic logic [6:0] pkt_len(input logic [15:0] r);
    return (r > 16'(PktBytes)) ? PktBytes : r[6:0];
  endfunction

  // read one ROM byte with packet size and ids patched in
  function automatic logic [7:0] rom_read(input logic [7:0] a, input logic [15:0] vid,
                                          input logic [15:0] pid);
    logic [7:0] r;
    begin
      if (a >= RomEnd) r = 8'h00;
      else if (a == 8'd7) r = 8'(EP0_PACKET_BYTES);
      else if (a == 8'd8) r = vid[7:0];
      else if (a == 8'd9) r = vid[15:8];
      else if (a == 8'd10) r = pid[7:0];
      else if (a == 8'd11) r = pid[15:8];
      else r = rom_byte(a[6:0]);
      return r;
    end
  endfunction

  // event decode
  always_comb begin
    logic        err;
    logic [15:0] dl;
    logic [6:0]  l;
    logic [8:0]  p;
    n_txh = HS_KEEP; n_rxh = HS_KEEP; n_bulk = BULK_NONE; n_len = '0;
    n_type = saved_type; n_code = saved_code; n_rem = remaining_bytes;
    n_rom_pointer = rom_pointer; n_pending = pending_address; n_bus = bus_address;
    n_cfgval = config_value; n_conf = is_configured; n_sleep = sleep_flag;
    n_intog = in_toggle; n_rxtog = rx_tog; n_line = line_coding;
    n_src_rom = 1'b0; n_src_line = 1'b0; n_src_cfg = 1'b0; n_walk = '0; n_base = '0;
    err = 1'b0; dl = '0; l = '0; p = '0;
    unique case (action)
      ACT_SETUP: begin
        n_type = request_type; n_code = request_code; n_rem = request_length;
        n_intog = 1'b1; n_rxtog = 1'b1;
        if (request_type[6:5] != 2'b00) begin
          if (request_type[6:5] == 2'b01) begin
            if (request_code == REQ_GET_LINE) begin
              n_src_line = 1'b1;
              if (n_rem > 16'd7) n_rem = 16'd7;
            end
          end else begin
            err = 1'b1;
          end
        end else begin
          case (request_code)
            REQ_GET_DESC: begin
              case (request_value[15:8])
                8'd1: begin n_base = 8'd0; dl = 16'h0012; end
                8'd2: begin n_base = 8'd18; dl = 16'h0043; end
                8'd3: begin
                  case (request_value[7:0])
                    8'd0: begin n_base = 8'd85; dl = 16'd4; end
                    8'd1: begin n_base = 8'd89; dl = 16'd14; end
                    8'd2: begin n_base = 8'd103; dl = 16'd20; end
                    default: err = 1'b1;
                  endcase
                end
                default: err = 1'b1;
              endcase
              if (!err) begin
                if (n_rem > dl) n_rem = dl;
                n_src_rom = 1'b1;
                l = pkt_len(n_rem);
                p = 9'(n_base) + 9'(l);
                n_rom_pointer = (p > 9'(RomBytes)) ? 7'(RomBytes) : p[6:0];
              end
            end
            REQ_SET_ADDRESS: n_pending = request_value[6:0];
            REQ_GET_CONFIG: begin
              n_src_cfg = 1'b1;
              if (n_rem > 16'd1) n_rem = 16'd1;
            end
            REQ_SET_CONFIG: begin
              n_cfgval = request_value[7:0];
              n_conf = (request_value[7:0] != 8'd0);
            end
            REQ_GET_IFACE: if (n_rem > 16'd1) n_rem = 16'd1;
            REQ_SET_IFACE: ;
            REQ_CLEAR_FEATURE: begin
              if (request_type[4:0] == 5'd2) begin
                if (request_value[7:0] == 8'd0) begin
                  if (request_index[7] && request_index[3:0] == 4'd3) n_bulk = BULK_IN;
                  else if (!request_index[7] && request_index[3:0] == 4'd2)
                    n_bulk = BULK_OUT;
                  else err = 1'b1;
                end else err = 1'b1;
              end else if (request_type[4:0] != 5'd0) err = 1'b1;
            end
            REQ_GET_STATUS: if (n_rem > 16'd2) n_rem = 16'd2;
            default: err = 1'b1;
          endcase
        end
        if (err) begin
          n_txh = HS_STALL; n_rxh = HS_STALL; n_rom_pointer = rom_pointer;
          n_bulk = BULK_NONE; n_src_rom = 1'b0; n_src_line = 1'b0;
          n_src_cfg = 1'b0;
        end else if (request_type[7]) begin
          l = pkt_len(n_rem);
          n_rem = n_rem - 16'(l);
          n_len = l; n_txh = HS_ACK; n_rxh = HS_NAK;
        end else if (n_rem == 16'd0) begin
          n_txh = HS_ACK; n_rxh = HS_NAK;
        end else begin
          n_txh = HS_NAK; n_rxh = HS_ACK;
        end
        n_walk = n_base;
      end
      ACT_IN_DONE: begin
        if (remaining_bytes == 16'd0) begin
          n_rxh = HS_ACK; n_rxtog = 1'b1;
        end
        if (saved_type[6:5] == 2'b00) begin
          if (saved_code == REQ_GET_DESC) begin
            l = pkt_len(remaining_bytes);
            n_src_rom = 1'b1; n_walk = {1'b0, rom_pointer};
            n_rem = remaining_bytes - 16'(l);
            p = 9'(rom_pointer) + 9'(l);
            n_rom_pointer = (p > 9'(RomBytes)) ? 7'(RomBytes) : p[6:0];
            n_len = l; n_intog = !in_toggle;
          end else if (saved_code == REQ_SET_ADDRESS) begin
            n_bus = pending_address;
          end
        end
      end
      ACT_OUT_DONE: begin
        if (toggle_ok && saved_type[6:5] == 2'b01 && saved_code == REQ_SET_LINE) begin
          for (int i = 0; i < 7; i++)
            if (7'(i) < out_count) n_line[8*i +: 8] = out_bytes[8*i +: 8];
        end
        n_txh = HS_ACK; n_intog = 1'b1;
      end
      ACT_BUS_RESET: begin
        n_cfgval = '0; n_pending = '0; n_sleep = 1'b0; n_conf = 1'b0; n_bus = '0;
        n_txh = HS_NAK; n_intog = 1'b0; n_rxh = HS_ACK; n_rxtog = 1'b0;
      end
      ACT_SUSPEND: n_sleep = suspended;
      default: ;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    out_valid = 1'b0;
    unique case (state)
      ST_IDLE: if (accept) state_next = ST_EMIT;
      ST_EMIT: begin
        out_valid = 1'b1;
        if (beat && last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // hold decoded event, advance byte counter per beat
  always_ff @(posedge clk) begin
    if (rst) begin
      vendor_id <= 16'h1A86; product_id <= 16'hFE0C;
      saved_type <= '0; saved_code <= '0; remaining_bytes <= '0;
      rom_pointer <= '0; pending_address <= '0; bus_address <= '0;
      config_value <= '0; is_configured <= 1'b0; sleep_flag <= 1'b0;
      in_toggle <= 1'b0; rx_tog <= 1'b0;
      line_coding <= 56'h0800000001C200;
      walk_idx <= '0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == CFG_VENDOR) vendor_id <= cfg_data;
        else product_id <= cfg_data;
      end
      if (accept) begin
        saved_type <= n_type; saved_code <= n_code; remaining_bytes <= n_rem;
        rom_pointer <= n_rom_pointer; pending_address <= n_pending;
        bus_address <= n_bus; config_value <= n_cfgval; is_configured <= n_conf;
        sleep_flag <= n_sleep; in_toggle <= n_intog; rx_tog <= n_rxtog;
        line_coding <= n_line;
        walk_idx <= '0;
      end else if (beat) begin
        walk_idx <= walk_idx + 7'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      txh <= n_txh; rxh <= n_rxh; bulk <= n_bulk; txlen <= n_len;
      src_rom <= n_src_rom; src_line <= n_src_line; src_cfg <= n_src_cfg;
      walk_addr <= n_walk; walk_count <= n_len;
    end
  end

  // select the byte of the current beat
  always_comb begin
    logic [8:0] a;
    a = 9'(walk_addr) + 9'(walk_idx);
    cur_byte = 8'h00;
    if (src_rom) begin
      cur_byte = (a >= 9'(RomBytes)) ? 8'h00 :
                 rom_read(a[7:0], vendor_id, product_id);
    end else if (src_line) begin
      if (walk_idx < 7'd7) cur_byte = line_coding[8*walk_idx[2:0] +: 8];
    end else if (src_cfg) begin
      if (walk_idx == 7'd0) cur_byte = config_value;
    end
  end

  assign tx_handshake   = txh;
  assign rx_handshake   = rxh;
  assign tx_toggle      = in_toggle;
  assign rx_toggle      = rx_tog;
  assign tx_length      = txlen;
  assign byte_valid     = (walk_count != 7'd0);
  assign data_byte      = byte_valid ? cur_byte : 8'h00;
  assign last           = (walk_count == 7'd0) || (walk_idx + 7'd1 == walk_count);
  assign device_address = bus_address;
  assign configured     = is_configured;
  assign bulk_reset     = bulk;
  assign sleeping       = sleep_flag;

endmodule

FILE: dv/usb_control_endpoint_engine_tb.sv
// Self-checking testbench for the endpoint-0 control engine.
`timescale 1ns / 100ps

module usb_control_endpoint_engine_tb;
  import usbcep_pkg::*;

  localparam int PktBytes = 64;
  localparam int RomEnd = 123;
  localparam int IdleLimit = 20000;

  typedef struct packed {
    logic [2:0]  act;
    logic [7:0]  rtype;
    logic [7:0]  rcode;
    logic [15:0] rval;
    logic [15:0] ridx;
    logic [15:0] rlen;
    logic        tog;
    logic [6:0]  ocnt;
    logic [55:0] obytes;
    logic        susp;
  } event_t;

  typedef struct packed {
    logic [1:0] txh;
    logic [1:0] rxh;
    logic       txt;
    logic       rxt;
    logic [6:0] txlen;
    logic [7:0] dbyte;
    logic       bval;
    logic       lst;
    logic [6:0] addr;
    logic       cfgd;
    logic [1:0] bulk;
    logic       slp;
  } beat_t;

  // Directed rows: event plus an optional typed-in first beat.
  typedef struct {
    event_t ev;
    bit     has_ref;
    beat_t  ref_beat;
  } row_t;

  logic        clk, rst;
  logic        in_valid, in_stall, out_valid, out_stall;
  logic        cfg_valid, cfg_ready;
  logic [0:0]  cfg_index;
  logic [15:0] cfg_data;
  event_t      drv;
  beat_t       got;

  usb_control_endpoint_engine u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(drv.act), .request_type(drv.rtype), .request_code(drv.rcode),
    .request_value(drv.rval), .request_index(drv.ridx),
    .request_length(drv.rlen), .toggle_ok(drv.tog), .out_count(drv.ocnt),
    .out_bytes(drv.obytes), .suspended(drv.susp),
    .out_valid(out_valid), .out_stall(out_stall),
    .tx_handshake(got.txh), .rx_handshake(got.rxh), .tx_toggle(got.txt),
    .rx_toggle(got.rxt), .tx_length(got.txlen), .data_byte(got.dbyte),
    .byte_valid(got.bval), .last(got.lst), .device_address(got.addr),
    .configured(got.cfgd), .bulk_reset(got.bulk), .sleeping(got.slp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow state of the endpoint.
  logic [15:0] m_vid, m_pid;
  logic [7:0]  m_type, m_code, m_cfgval;
  logic [15:0] m_rem;
  int          m_ptr;
  logic [6:0]  m_pend, m_addr;
  logic        m_cfgd, m_slp, m_intog, m_rxtog;
  logic [55:0] m_line;

  beat_t beats_due[$];
  int    errors = 0;
  int    n_beats = 0;
  int    idle_cycles = 0;
  bit    in_idle_ok = 1, out_idle_ok = 1;
  bit    n_extra_check = 0;
  beat_t extra_ref;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] desc_byte(int a);
    if (a >= RomEnd) return 8'h00;
    case (a)
      7: return 8'(PktBytes);
      8: return m_vid[7:0];
      9: return m_vid[15:8];
      10: return m_pid[7:0];
      11: return m_pid[15:8];
      default: return rom_byte(7'(a));
    endcase
  endfunction

  function automatic int chunk(int rem);
    return rem > PktBytes ? PktBytes : rem;
  endfunction

  task automatic shadow_reset();
    m_vid = 16'h1A86; m_pid = 16'hFE0C;
    m_type = 0; m_code = 0; m_rem = 0; m_ptr = 0; m_pend = 0; m_addr = 0;
    m_cfgval = 0; m_cfgd = 0; m_slp = 0; m_intog = 0; m_rxtog = 0;
    m_line = 56'h0800000001C200;
  endtask

  // Advance the shadow state by one event and queue its beats.
  task automatic predict_event(input event_t e);
    logic [7:0] pay [64];
    int npay, txlen, base, dl, l, n;
    logic [1:0] txh, rxh, bulk;
    bit err;
    beat_t b;
    npay = 0; txlen = 0; txh = HS_KEEP; rxh = HS_KEEP; bulk = BULK_NONE;
    err = 0;
    for (int i = 0; i < 64; i++) pay[i] = 0;
    case (e.act)
      ACT_SETUP: begin
        m_type = e.rtype; m_code = e.rcode; m_rem = e.rlen;
        m_intog = 1; m_rxtog = 1;
        if (e.rtype[6:5] != 0) begin
          if (e.rtype[6:5] == 2'b01) begin
            if (e.rcode == REQ_GET_LINE) begin
              for (int i = 0; i < 7; i++) pay[i] = m_line[8*i +: 8];
              if (m_rem > 7) m_rem = 7;
            end
          end else err = 1;
        end else begin
          case (e.rcode)
            REQ_GET_DESC: begin
              base = 0; dl = 0;
              case (e.rval[15:8])
                1: dl = desc_byte(0);
                2: begin base = 18; dl = {desc_byte(21), desc_byte(20)}; end
                3: begin
                  case (e.rval[7:0])
                    0: base = 85;
                    1: base = 89;
                    2: base = 103;
                    default: err = 1;
                  endcase
                  if (!err) dl = desc_byte(base);
                end
                default: err = 1;
              endcase
              if (!err) begin
                if (m_rem > dl) m_rem = 16'(dl);
                l = chunk(m_rem);
                for (int i = 0; i < l; i++) pay[i] = desc_byte(base + i);
                base += l;
                m_ptr = base > RomEnd ? RomEnd : base;
              end
            end
            REQ_SET_ADDRESS: m_pend = e.rval[6:0];
            REQ_GET_CONFIG: begin
              pay[0] = m_cfgval;
              if (m_rem > 1) m_rem = 1;
            end
            REQ_SET_CONFIG: begin
              m_cfgval = e.rval[7:0];
              m_cfgd = m_cfgval != 0;
            end
            REQ_GET_IFACE: if (m_rem > 1) m_rem = 1;
            REQ_SET_IFACE: ;
            REQ_CLEAR_FEATURE: begin
              if (e.rtype[4:0] == 2) begin
                if (e.rval[7:0] == 0) begin
                  if (e.ridx[7] && e.ridx[3:0] == 3) bulk = BULK_IN;
                  else if (!e.ridx[7] && e.ridx[3:0] == 2) bulk = BULK_OUT;
                  else err = 1;
                end else err = 1;
              end else if (e.rtype[4:0] != 0) err = 1;
            end
            REQ_GET_STATUS: if (m_rem > 2) m_rem = 2;
            default: err = 1;
          endcase
        end
        if (err) begin
          txh = HS_STALL; rxh = HS_STALL;
        end else if (e.rtype[7]) begin
          l = chunk(m_rem);
          m_rem -= 16'(l);
          txlen = l; npay = l; txh = HS_ACK; rxh = HS_NAK;
        end else if (m_rem == 0) begin
          txh = HS_ACK; rxh = HS_NAK;
        end else begin
          txh = HS_NAK; rxh = HS_ACK;
        end
      end
      ACT_IN_DONE: begin
        if (m_rem == 0) begin
          rxh = HS_ACK; m_rxtog = 1;
        end
        if (m_type[6:5] == 0) begin
          if (m_code == REQ_GET_DESC) begin
            l = chunk(m_rem);
            for (int i = 0; i < l; i++) pay[i] = desc_byte(m_ptr + i);
            m_rem -= 16'(l);
            m_ptr = m_ptr + l > RomEnd ? RomEnd : m_ptr + l;
            txlen = l; npay = l; m_intog ^= 1'b1;
          end else if (m_code == REQ_SET_ADDRESS) m_addr = m_pend;
        end
      end
      ACT_OUT_DONE: begin
        if (e.tog && m_type[6:5] == 2'b01 && m_code == REQ_SET_LINE)
          for (int i = 0; i < 7; i++)
            if (i < e.ocnt) m_line[8*i +: 8] = e.obytes[8*i +: 8];
        txh = HS_ACK; m_intog = 1;
      end
      ACT_BUS_RESET: begin
        m_cfgval = 0; m_pend = 0; m_slp = 0; m_cfgd = 0; m_addr = 0;
        txh = HS_NAK; m_intog = 0; rxh = HS_ACK; m_rxtog = 0;
      end
      ACT_SUSPEND: m_slp = e.susp;
      default: ;
    endcase
    n = npay == 0 ? 1 : npay;
    for (int i = 0; i < n; i++) begin
      b.txh = txh; b.rxh = rxh; b.txt = m_intog; b.rxt = m_rxtog;
      b.txlen = 7'(txlen); b.dbyte = npay ? pay[i] : 8'h00;
      b.bval = npay != 0; b.lst = i == n - 1; b.addr = m_addr;
      b.cfgd = m_cfgd; b.bulk = bulk; b.slp = m_slp;
      beats_due.push_back(b);
    end
  endtask

  // Check each taken beat against the oldest expected beat.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (beats_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat %p", $time, got);
      end else begin
        beat_t e;
        e = beats_due.pop_front();
        if (n_extra_check) begin
          n_extra_check = 0;
          if (extra_ref !== e) begin
            errors++;
            $display("%0t: table row: expected %p predicted %p", $time, extra_ref, e);
          end
        end
        if (got !== e) begin
          errors++;
          $display("%0t: mismatch: expected %p actual %p", $time, e, got);
        end
      end
      n_beats++;
    end
  end

  // Stall the output side at random.
  always @(posedge clk) begin
    if (rst) out_stall <= 0;
    else out_stall <= out_idle_ok && ($urandom_range(99) < 34);
  end

  // Watchdog on cycles with no beat moving.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_event(input event_t e);
    while (in_idle_ok && $urandom_range(99) < 34) @(posedge clk);
    drv <= e;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    predict_event(e);
    in_valid <= 0;
    // the engine stalls its input once it has taken an event
    @(posedge clk);
  endtask

  task automatic drain();
    while (beats_due.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [15:0] val);
    cfg_index <= idx; cfg_data <= val; cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    if (idx == CFG_VENDOR) m_vid = val; else m_pid = val;
    @(posedge clk);
  endtask

  function automatic event_t mk_setup(logic [7:0] t, logic [7:0] c, logic [15:0] v,
                                      logic [15:0] i, logic [15:0] l);
    event_t e;
    e = '0;
    e.act = ACT_SETUP; e.rtype = t; e.rcode = c; e.rval = v; e.ridx = i; e.rlen = l;
    return e;
  endfunction

  function automatic event_t mk_act(logic [2:0] a);
    event_t e;
    e = '0;
    e.act = a;
    return e;
  endfunction

  function automatic event_t rand_noise();
    event_t e;
    e = event_t'({$urandom, $urandom, $urandom, $urandom, 4'($urandom)});
    e.ocnt = 7'($urandom_range(64));
    if ($urandom_range(3) != 0 && e.act > ACT_SUSPEND) e.act = 3'($urandom_range(4));
    return e;
  endfunction

  // Well-formed control transfer with random content, or noise.
  task automatic random_transfer();
    event_t e;
    int k;
    k = $urandom_range(9);
    e = rand_noise();
    case (k)
      0, 1, 2: begin
        e = mk_setup(8'h80, REQ_GET_DESC, {8'($urandom_range(1, 3)), 8'($urandom_range(3))},
                     16'($urandom), $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(255)));
        send_event(e);
        repeat ($urandom_range(1, 3)) send_event(mk_act(ACT_IN_DONE));
        send_event(mk_act(ACT_OUT_DONE));
      end
      3: begin
        send_event(mk_setup(8'h00, REQ_SET_ADDRESS, 16'($urandom), 0, 0));
        send_event(mk_act(ACT_IN_DONE));
      end
      4: begin
        e = mk_setup(8'h21, REQ_SET_LINE, 0, 0, 7);
        send_event(e);
        e = rand_noise();
        e.act = ACT_OUT_DONE;
        send_event(e);
        send_event(mk_act(ACT_IN_DONE));
        send_event(mk_setup(8'hA1, REQ_GET_LINE, 0, 0, 16'($urandom_range(12))));
      end
      5: begin
        send_event(mk_setup(8'($urandom_range(1) ? 8'h80 : 8'h00) | 8'($urandom_range(2)),
                            8'($urandom_range(11)), 16'($urandom_range(3)),
                            16'($urandom), 16'($urandom_range(4))));
        send_event(mk_act(ACT_IN_DONE));
      end
      default: send_event(e);
    endcase
  endtask

  row_t rows[$];

  initial begin
    row_t r;
    beat_t b;
    event_t e;
    rst = 1; in_valid = 0; cfg_valid = 0; cfg_index = 0; cfg_data = 0;
    drv = '0;
    shadow_reset();
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed table; stall and reserved action rows carry typed-in beats.
    b = '0; b.txh = HS_STALL; b.rxh = HS_STALL; b.txt = 1; b.rxt = 1; b.lst = 1;
    r.has_ref = 1; r.ref_beat = b;
    r.ev = mk_setup(8'h00, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF); rows.push_back(r);
    r.ev = mk_setup(8'h40, REQ_GET_STATUS, 0, 0, 0); rows.push_back(r);
    b = '0; b.txh = HS_KEEP; b.rxh = HS_KEEP; b.txt = 1; b.rxt = 1; b.lst = 1;
    r.ref_beat = b; r.ev = '1; rows.push_back(r);
    r.has_ref = 0;
    r.ev = mk_setup(8'h80, REQ_GET_DESC, 16'h0100, 0, 16'hFFFF); rows.push_back(r);
    r.ev = mk_setup(8'h80, REQ_GET_DESC, 16'h0200, 0, 16'hFFFF); rows.push_back(r);
    r.ev = mk_act(ACT_IN_DONE); rows.push_back(r);
    r.ev = mk_act(ACT_IN_DONE); rows.push_back(r);
    r.ev = mk_setup(8'h80, REQ_GET_DESC, 16'h0302, 0, 16'h00FF); rows.push_back(r);
    r.ev = mk_act(ACT_IN_DONE); rows.push_back(r);
    r.ev = mk_setup(8'h80, REQ_GET_DESC, 16'h0303, 0, 9); rows.push_back(r);
    r.ev = mk_setup(8'h00, REQ_SET_ADDRESS, 16'hFFFF, 0, 0); rows.push_back(r);
    r.ev = mk_act(ACT_IN_DONE); rows.push_back(r);
    r.ev = mk_setup(8'h00, REQ_SET_CONFIG, 16'h00FF, 0, 0); rows.push_back(r);
    r.ev = mk_setup(8'h80, REQ_GET_CONFIG, 0, 0, 16'hFFFF); rows.push_back(r);
    r.ev = mk_setup(8'h81, REQ_GET_IFACE, 0, 0, 5); rows.push_back(r);
    r.ev = mk_setup(8'h01, REQ_SET_IFACE, 0, 0, 0); rows.push_back(r);
    r.ev = mk_setup(8'h02, REQ_CLEAR_FEATURE, 0, 16'h0083, 0); rows.push_back(r);
    r.ev = mk_setup(8'h02, REQ_CLEAR_FEATURE, 0, 16'h0002, 0); rows.push_back(r);
    r.ev = mk_setup(8'h02, REQ_CLEAR_FEATURE, 0, 16'h0001, 0); rows.push_back(r);
    r.ev = mk_setup(8'h21, REQ_SET_LINE, 0, 0, 7); rows.push_back(r);
    r.ev = mk_act(ACT_OUT_DONE); r.ev.tog = 1; r.ev.ocnt = 64; r.ev.obytes = '1;
    rows.push_back(r);
    r.ev = mk_setup(8'hA1, REQ_GET_LINE, 0, 0, 16'hFFFF); rows.push_back(r);
    r.ev = mk_act(ACT_SUSPEND); r.ev.susp = 1; rows.push_back(r);
    r.ev = mk_act(ACT_BUS_RESET); rows.push_back(r);

    foreach (rows[i]) begin
      if (rows[i].has_ref) begin
        while (beats_due.size() != 0) @(posedge clk);
        extra_ref = rows[i].ref_beat; n_extra_check = 1;
      end
      send_event(rows[i].ev);
    end

    // Register extremes, then random phases.
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0: begin write_reg(CFG_VENDOR, 16'h0000); write_reg(CFG_PRODUCT, 16'hFFFF); end
        1: begin write_reg(CFG_VENDOR, 16'hFFFF); write_reg(CFG_PRODUCT, 16'h0000); end
        2: begin write_reg(CFG_VENDOR, 16'($urandom)); write_reg(CFG_PRODUCT, 16'($urandom)); end
        default: begin write_reg(CFG_VENDOR, 16'h1A86); write_reg(CFG_PRODUCT, 16'hFE0C); end
      endcase
      send_event(mk_setup(8'h80, REQ_GET_DESC, 16'h0100, 0, 18));
      if (ph == 1) begin
        in_idle_ok = 0; out_idle_ok = 0;
      end
      for (int k = 0; k < 40; k++) random_transfer();
      in_idle_ok = 1; out_idle_ok = 1;
    end

    drain();
    $display("Ran %0d beats over directed requests, descriptor walks, line coding", n_beats);
    $display("and four vendor/product settings with random idles on both sides.");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
